FILE: rtl/core/cplc_pkg.sv
package cplc_pkg;

    localparam int MAX_VERTICES = 8;
    localparam int COORD_WIDTH  = 12;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int VCOUNT_W   = 4;
    localparam int VCOUNT_RST = 4;
    localparam int VCOUNT_MIN = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VCOUNT,
        CFG_VERT_0_1,
        CFG_VERT_2_3,
        CFG_VERT_4_5,
        CFG_VERT_6_7
    } t_cfg_reg;

    // Arithmetic widths
    localparam int DIFF_W  = COORD_WIDTH + 1;          // coordinate differences
    localparam int PROD_W  = 2 * DIFF_W;               // normal times difference
    localparam int SUM_W   = PROD_W + 1;               // N and D
    localparam int FRAC_W  = SUM_W + 1;                // t numerator and denominator
    localparam int CMP_W   = 2 * FRAC_W;               // cross products of fractions
    localparam int CPROD_W = DIFF_W + FRAC_W;          // coordinate products
    localparam int NUM_W   = CPROD_W + 1;              // coordinate numerator
    localparam int ACC_W   = NUM_W + 1;                // dividend, rounding included
    localparam int DEN_W   = FRAC_W + 1;               // divisor, doubled denominator
    localparam int QUO_W   = COORD_WIDTH + 1;          // quotient bits, one per stage

    localparam int VIDX_W    = $clog2(MAX_VERTICES);
    localparam int CNT_W     = $clog2(MAX_VERTICES + 1);
    localparam int TREE_LVLS = $clog2(MAX_VERTICES);
    localparam int TREE_N    = 1 << TREE_LVLS;

    // Pipeline stage numbers
    localparam int ST_CAND    = 3;
    localparam int ST_FPROD   = ST_CAND + 2 * TREE_LVLS + 1;
    localparam int ST_PREP    = ST_FPROD + 1;
    localparam int ST_OUT     = ST_PREP + QUO_W + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_start;
        logic signed [COORD_WIDTH-1:0] y_start;
        logic signed [COORD_WIDTH-1:0] x_end;
        logic signed [COORD_WIDTH-1:0] y_end;
    } t_seg_in;

    typedef struct packed {
        logic                          visible;
        logic signed [COORD_WIDTH-1:0] clip_x_start;
        logic signed [COORD_WIDTH-1:0] clip_y_start;
        logic signed [COORD_WIDTH-1:0] clip_x_end;
        logic signed [COORD_WIDTH-1:0] clip_y_end;
    } t_clip_out;

    typedef struct packed {
        logic signed [FRAC_W-1:0] num;
        logic signed [FRAC_W-1:0] den;
    } t_frac;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x0;
        logic signed [COORD_WIDTH-1:0] y0;
        logic signed [DIFF_W-1:0]      dx;
        logic signed [DIFF_W-1:0]      dy;
    } t_geo;

    localparam t_frac LO_INIT = '{num: FRAC_W'(0), den: FRAC_W'(1)};
    localparam t_frac HI_INIT = '{num: FRAC_W'(1), den: FRAC_W'(1)};

endpackage

FILE: rtl/core/convex_polygon_line_clipper_unit.sv
// Cyrus-Beck clipper: one segment against a convex window polygon.
// Accepts one transaction per cycle while the output is not stalled.
// Edge terms for all vertices run in parallel lanes, t bounds reduce through a
// registered compare tree, and each endpoint coordinate goes through a 13-stage divider.
// A stalled result freezes the whole pipeline, so o_stall follows i_stall while o_valid is high.
// Reset empties the pipeline, sets vertex_count to 4 and all vertices to (0, 0).
module convex_polygon_line_clipper_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  cplc_pkg::t_seg_in                   i_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output cplc_pkg::t_clip_out                 o_data,
    input  logic                                i_cfg_we,
    input  logic [cplc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cplc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Configuration
    logic [cplc_pkg::VCOUNT_W-1:0]           r_vcount;
    logic signed [cplc_pkg::COORD_WIDTH-1:0] r_vx [0:cplc_pkg::MAX_VERTICES-1];
    logic signed [cplc_pkg::COORD_WIDTH-1:0] r_vy [0:cplc_pkg::MAX_VERTICES-1];
    logic [cplc_pkg::CFG_IDX_W-1:0]          w_pair;
    logic                                    w_pair_ok;

    // Edge normals
    logic [cplc_pkg::CNT_W-1:0]              w_nv;
    logic signed [cplc_pkg::DIFF_W-1:0]      w_nx [0:cplc_pkg::MAX_VERTICES-1];
    logic signed [cplc_pkg::DIFF_W-1:0]      w_ny [0:cplc_pkg::MAX_VERTICES-1];
    logic                                    w_act [0:cplc_pkg::MAX_VERTICES-1];

    // Pipeline control
    logic                                    w_adv;
    logic                                    r_vld [0:cplc_pkg::NUM_STAGES-1];

    // Stages 0 to 2
    cplc_pkg::t_seg_in                       r_in;
    cplc_pkg::t_geo                          n_geo;
    cplc_pkg::t_geo                          r_geo [1:cplc_pkg::ST_FPROD-1];
    logic signed [cplc_pkg::PROD_W-1:0]      n_px [0:cplc_pkg::MAX_VERTICES-1];
    logic signed [cplc_pkg::PROD_W-1:0]      n_py [0:cplc_pkg::MAX_VERTICES-1];
    logic signed [cplc_pkg::PROD_W-1:0]      n_qx [0:cplc_pkg::MAX_VERTICES-1];
    logic signed [cplc_pkg::PROD_W-1:0]      n_qy [0:cplc_pkg::MAX_VERTICES-1];
    logic signed [cplc_pkg::PROD_W-1:0]      r_px [0:cplc_pkg::MAX_VERTICES-1];
    logic signed [cplc_pkg::PROD_W-1:0]      r_py [0:cplc_pkg::MAX_VERTICES-1];
    logic signed [cplc_pkg::PROD_W-1:0]      r_qx [0:cplc_pkg::MAX_VERTICES-1];
    logic signed [cplc_pkg::PROD_W-1:0]      r_qy [0:cplc_pkg::MAX_VERTICES-1];
    logic                                    r_act [0:cplc_pkg::MAX_VERTICES-1];
    logic signed [cplc_pkg::SUM_W-1:0]       r_num [0:cplc_pkg::MAX_VERTICES-1];
    logic signed [cplc_pkg::SUM_W-1:0]       r_dot [0:cplc_pkg::MAX_VERTICES-1];
    logic                                    r_act2 [0:cplc_pkg::MAX_VERTICES-1];

    // Candidates and reduction tree
    logic                                    n_rej;
    logic                                    r_rej [cplc_pkg::ST_CAND:cplc_pkg::ST_FPROD-1];
    cplc_pkg::t_frac n_lo0 [0:cplc_pkg::TREE_N-1];
    cplc_pkg::t_frac n_hi0 [0:cplc_pkg::TREE_N-1];
    cplc_pkg::t_frac r_lo [0:cplc_pkg::TREE_LVLS][0:cplc_pkg::TREE_N-1];
    cplc_pkg::t_frac r_hi [0:cplc_pkg::TREE_LVLS][0:cplc_pkg::TREE_N-1];
    cplc_pkg::t_frac r_tl [0:cplc_pkg::TREE_LVLS-1][0:cplc_pkg::TREE_N-1];
    cplc_pkg::t_frac r_th [0:cplc_pkg::TREE_LVLS-1][0:cplc_pkg::TREE_N-1];
    cplc_pkg::t_frac n_lo [0:cplc_pkg::TREE_LVLS-1][0:cplc_pkg::TREE_N-1];
    cplc_pkg::t_frac n_hi [0:cplc_pkg::TREE_LVLS-1][0:cplc_pkg::TREE_N-1];
    logic signed [cplc_pkg::CMP_W-1:0] n_pla [0:cplc_pkg::TREE_LVLS-1][0:cplc_pkg::TREE_N/2-1];
    logic signed [cplc_pkg::CMP_W-1:0] n_plb [0:cplc_pkg::TREE_LVLS-1][0:cplc_pkg::TREE_N/2-1];
    logic signed [cplc_pkg::CMP_W-1:0] n_pha [0:cplc_pkg::TREE_LVLS-1][0:cplc_pkg::TREE_N/2-1];
    logic signed [cplc_pkg::CMP_W-1:0] n_phb [0:cplc_pkg::TREE_LVLS-1][0:cplc_pkg::TREE_N/2-1];
    logic signed [cplc_pkg::CMP_W-1:0] r_pla [0:cplc_pkg::TREE_LVLS-1][0:cplc_pkg::TREE_N/2-1];
    logic signed [cplc_pkg::CMP_W-1:0] r_plb [0:cplc_pkg::TREE_LVLS-1][0:cplc_pkg::TREE_N/2-1];
    logic signed [cplc_pkg::CMP_W-1:0] r_pha [0:cplc_pkg::TREE_LVLS-1][0:cplc_pkg::TREE_N/2-1];
    logic signed [cplc_pkg::CMP_W-1:0] r_phb [0:cplc_pkg::TREE_LVLS-1][0:cplc_pkg::TREE_N/2-1];

    // Final products
    cplc_pkg::t_frac                         w_flo;
    cplc_pkg::t_frac                         w_fhi;
    logic signed [cplc_pkg::CMP_W-1:0]       r_fpa;
    logic signed [cplc_pkg::CMP_W-1:0]       r_fpb;
    logic                                    r_frej;
    logic signed [cplc_pkg::CPROD_W-1:0]     n_cb [0:3];
    logic signed [cplc_pkg::CPROD_W-1:0]     n_cd [0:3];
    logic signed [cplc_pkg::FRAC_W-1:0]      n_cden [0:3];
    logic signed [cplc_pkg::CPROD_W-1:0]     r_cb [0:3];
    logic signed [cplc_pkg::CPROD_W-1:0]     r_cd [0:3];
    logic signed [cplc_pkg::FRAC_W-1:0]      r_cden [0:3];

    // Divider
    logic [cplc_pkg::ACC_W-1:0]              n_dv_rem [0:cplc_pkg::QUO_W][0:3];
    logic [cplc_pkg::QUO_W-1:0]              n_dv_q   [0:cplc_pkg::QUO_W][0:3];
    logic [cplc_pkg::DEN_W-1:0]              n_dv_b0  [0:3];
    logic                                    n_dv_neg0 [0:3];
    logic                                    n_dv_vis0;
    logic [cplc_pkg::ACC_W-1:0]              r_dv_rem [0:cplc_pkg::QUO_W][0:3];
    logic [cplc_pkg::QUO_W-1:0]              r_dv_q   [0:cplc_pkg::QUO_W][0:3];
    logic [cplc_pkg::DEN_W-1:0]              r_dv_b   [0:cplc_pkg::QUO_W][0:3];
    logic                                    r_dv_neg [0:cplc_pkg::QUO_W][0:3];
    logic                                    r_dv_vis [0:cplc_pkg::QUO_W];

    cplc_pkg::t_clip_out                     n_out;
    cplc_pkg::t_clip_out                     r_out;

    // ---------------------------------------------------------------- config
    assign w_pair    = i_cfg_idx - cplc_pkg::CFG_VERT_0_1;
    assign w_pair_ok = (i_cfg_idx >= cplc_pkg::CFG_VERT_0_1)
                    && (i_cfg_idx <= cplc_pkg::CFG_VERT_6_7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= cplc_pkg::VCOUNT_W'(cplc_pkg::VCOUNT_RST);
            for (int k = 0; k < cplc_pkg::MAX_VERTICES; k++) begin
                r_vx[k] <= '0;
                r_vy[k] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == cplc_pkg::CFG_VCOUNT) begin
                r_vcount <= i_cfg_data[cplc_pkg::VCOUNT_W-1:0];
            end
            for (int k = 0; k < cplc_pkg::MAX_VERTICES; k++) begin
                if (w_pair_ok && w_pair == cplc_pkg::CFG_IDX_W'(k >> 1)) begin
                    r_vx[k] <= i_cfg_data[(k & 1) * 2 * cplc_pkg::COORD_WIDTH
                                          +: cplc_pkg::COORD_WIDTH];
                    r_vy[k] <= i_cfg_data[((k & 1) * 2 + 1) * cplc_pkg::COORD_WIDTH
                                          +: cplc_pkg::COORD_WIDTH];
                end
            end
        end
    end

    // Clamp the vertex count and form the inward normal of every edge
    always_comb begin
        logic [cplc_pkg::VIDX_W-1:0] jn;
        jn = '0;
        if (r_vcount < cplc_pkg::VCOUNT_W'(cplc_pkg::VCOUNT_MIN)) begin
            w_nv = cplc_pkg::CNT_W'(cplc_pkg::VCOUNT_MIN);
        end else if (int'(r_vcount) > cplc_pkg::MAX_VERTICES) begin
            w_nv = cplc_pkg::CNT_W'(cplc_pkg::MAX_VERTICES);
        end else begin
            w_nv = cplc_pkg::CNT_W'(r_vcount);
        end
        for (int j = 0; j < cplc_pkg::MAX_VERTICES; j++) begin
            jn = ((j + 1) == int'(w_nv)) ? '0 : cplc_pkg::VIDX_W'(j + 1);
            w_nx[j]  = cplc_pkg::DIFF_W'(r_vy[j]) - cplc_pkg::DIFF_W'(r_vy[jn]);
            w_ny[j]  = cplc_pkg::DIFF_W'(r_vx[jn]) - cplc_pkg::DIFF_W'(r_vx[j]);
            w_act[j] = j < int'(w_nv);
        end
    end

    // ---------------------------------------------------------------- stages
    assign w_adv   = !(r_vld[cplc_pkg::NUM_STAGES-1] && i_stall);
    assign o_stall = !w_adv;
    assign o_valid = r_vld[cplc_pkg::NUM_STAGES-1];
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < cplc_pkg::NUM_STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < cplc_pkg::NUM_STAGES; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // Stage 1: edge products
    always_comb begin
        logic signed [cplc_pkg::DIFF_W-1:0] rx;
        logic signed [cplc_pkg::DIFF_W-1:0] ry;
        rx = '0;
        ry = '0;
        n_geo.x0 = r_in.x_start;
        n_geo.y0 = r_in.y_start;
        n_geo.dx = cplc_pkg::DIFF_W'(r_in.x_end) - cplc_pkg::DIFF_W'(r_in.x_start);
        n_geo.dy = cplc_pkg::DIFF_W'(r_in.y_end) - cplc_pkg::DIFF_W'(r_in.y_start);
        for (int j = 0; j < cplc_pkg::MAX_VERTICES; j++) begin
            rx = cplc_pkg::DIFF_W'(r_in.x_start) - cplc_pkg::DIFF_W'(r_vx[j]);
            ry = cplc_pkg::DIFF_W'(r_in.y_start) - cplc_pkg::DIFF_W'(r_vy[j]);
            n_px[j] = cplc_pkg::PROD_W'(w_nx[j]) * cplc_pkg::PROD_W'(rx);
            n_py[j] = cplc_pkg::PROD_W'(w_ny[j]) * cplc_pkg::PROD_W'(ry);
            n_qx[j] = cplc_pkg::PROD_W'(w_nx[j]) * cplc_pkg::PROD_W'(n_geo.dx);
            n_qy[j] = cplc_pkg::PROD_W'(w_ny[j]) * cplc_pkg::PROD_W'(n_geo.dy);
        end
    end

    // Stage 3: entering and leaving candidates, parallel rejection
    always_comb begin
        n_rej = 1'b0;
        for (int j = 0; j < cplc_pkg::TREE_N; j++) begin
            n_lo0[j] = cplc_pkg::LO_INIT;
            n_hi0[j] = cplc_pkg::HI_INIT;
        end
        for (int j = 0; j < cplc_pkg::MAX_VERTICES; j++) begin
            if (r_act2[j]) begin
                if (r_dot[j] > 0) begin
                    n_lo0[j].num = -cplc_pkg::FRAC_W'(r_num[j]);
                    n_lo0[j].den = cplc_pkg::FRAC_W'(r_dot[j]);
                end else if (r_dot[j] < 0) begin
                    n_hi0[j].num = cplc_pkg::FRAC_W'(r_num[j]);
                    n_hi0[j].den = -cplc_pkg::FRAC_W'(r_dot[j]);
                end else if (r_num[j] < 0) begin
                    n_rej = 1'b1;
                end
            end
        end
    end

    // Tree: cross-multiply pairs, then keep the larger lower bound and smaller upper bound
    always_comb begin
        for (int l = 0; l < cplc_pkg::TREE_LVLS; l++) begin
            for (int k = 0; k < cplc_pkg::TREE_N / 2; k++) begin
                n_pla[l][k] = cplc_pkg::CMP_W'(r_lo[l][2*k].num)
                            * cplc_pkg::CMP_W'(r_lo[l][2*k+1].den);
                n_plb[l][k] = cplc_pkg::CMP_W'(r_lo[l][2*k+1].num)
                            * cplc_pkg::CMP_W'(r_lo[l][2*k].den);
                n_pha[l][k] = cplc_pkg::CMP_W'(r_hi[l][2*k].num)
                            * cplc_pkg::CMP_W'(r_hi[l][2*k+1].den);
                n_phb[l][k] = cplc_pkg::CMP_W'(r_hi[l][2*k+1].num)
                            * cplc_pkg::CMP_W'(r_hi[l][2*k].den);
            end
            for (int k = 0; k < cplc_pkg::TREE_N; k++) begin
                n_lo[l][k] = cplc_pkg::LO_INIT;
                n_hi[l][k] = cplc_pkg::HI_INIT;
            end
            for (int k = 0; k < cplc_pkg::TREE_N / 2; k++) begin
                n_lo[l][k] = (r_pla[l][k] > r_plb[l][k]) ? r_tl[l][2*k] : r_tl[l][2*k+1];
                n_hi[l][k] = (r_pha[l][k] < r_phb[l][k]) ? r_th[l][2*k] : r_th[l][2*k+1];
            end
        end
    end

    // Final compare products and coordinate products
    assign w_flo = r_lo[cplc_pkg::TREE_LVLS][0];
    assign w_fhi = r_hi[cplc_pkg::TREE_LVLS][0];

    always_comb begin
        cplc_pkg::t_geo g;
        g = r_geo[cplc_pkg::ST_FPROD-1];
        n_cden[0] = w_flo.den;
        n_cden[1] = w_flo.den;
        n_cden[2] = w_fhi.den;
        n_cden[3] = w_fhi.den;
        n_cb[0] = cplc_pkg::CPROD_W'(g.x0) * cplc_pkg::CPROD_W'(w_flo.den);
        n_cb[1] = cplc_pkg::CPROD_W'(g.y0) * cplc_pkg::CPROD_W'(w_flo.den);
        n_cb[2] = cplc_pkg::CPROD_W'(g.x0) * cplc_pkg::CPROD_W'(w_fhi.den);
        n_cb[3] = cplc_pkg::CPROD_W'(g.y0) * cplc_pkg::CPROD_W'(w_fhi.den);
        n_cd[0] = cplc_pkg::CPROD_W'(g.dx) * cplc_pkg::CPROD_W'(w_flo.num);
        n_cd[1] = cplc_pkg::CPROD_W'(g.dy) * cplc_pkg::CPROD_W'(w_flo.num);
        n_cd[2] = cplc_pkg::CPROD_W'(g.dx) * cplc_pkg::CPROD_W'(w_fhi.num);
        n_cd[3] = cplc_pkg::CPROD_W'(g.dy) * cplc_pkg::CPROD_W'(w_fhi.num);
    end

    // Divider set-up: |num| rounded by adding half the divisor, then one bit a stage
    always_comb begin
        logic signed [cplc_pkg::NUM_W-1:0] num;
        logic [cplc_pkg::NUM_W-1:0]        mag;
        logic [cplc_pkg::ACC_W-1:0]        sub;
        num = '0;
        mag = '0;
        sub = '0;
        n_dv_vis0 = !r_frej && !(r_fpa > r_fpb);
        for (int c = 0; c < 4; c++) begin
            num = cplc_pkg::NUM_W'(r_cb[c]) + cplc_pkg::NUM_W'(r_cd[c]);
            n_dv_neg0[c] = num[cplc_pkg::NUM_W-1];
            mag = n_dv_neg0[c] ? -num : num;
            n_dv_rem[0][c] = (cplc_pkg::ACC_W'(mag) << 1) + cplc_pkg::ACC_W'(r_cden[c]);
            n_dv_q[0][c]   = '0;
            n_dv_b0[c]     = cplc_pkg::DEN_W'(r_cden[c]) << 1;
        end
        for (int k = 1; k <= cplc_pkg::QUO_W; k++) begin
            for (int c = 0; c < 4; c++) begin
                sub = cplc_pkg::ACC_W'(r_dv_b[k-1][c]) << (cplc_pkg::QUO_W - k);
                n_dv_rem[k][c] = r_dv_rem[k-1][c];
                n_dv_q[k][c]   = r_dv_q[k-1][c];
                if (r_dv_rem[k-1][c] >= sub) begin
                    n_dv_rem[k][c] = r_dv_rem[k-1][c] - sub;
                    n_dv_q[k][c][cplc_pkg::QUO_W-k] = 1'b1;
                end
            end
        end
    end

    // Output: apply sign, zero the coordinates of a rejected segment
    always_comb begin
        logic [cplc_pkg::QUO_W-1:0]       sq [0:3];
        logic [cplc_pkg::COORD_WIDTH-1:0] cv [0:3];
        for (int c = 0; c < 4; c++) begin
            sq[c] = r_dv_neg[cplc_pkg::QUO_W][c] ? (cplc_pkg::QUO_W'(0) - r_dv_q[cplc_pkg::QUO_W][c])
                                                 : r_dv_q[cplc_pkg::QUO_W][c];
            cv[c] = r_dv_vis[cplc_pkg::QUO_W] ? sq[c][cplc_pkg::COORD_WIDTH-1:0] : '0;
        end
        n_out.visible      = r_dv_vis[cplc_pkg::QUO_W];
        n_out.clip_x_start = cv[0];
        n_out.clip_y_start = cv[1];
        n_out.clip_x_end   = cv[2];
        n_out.clip_y_end   = cv[3];
    end

    // Payload registers: hold everything while the output is stalled
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in <= i_data;

            r_geo[1] <= n_geo;
            for (int s = 2; s < cplc_pkg::ST_FPROD; s++) begin
                r_geo[s] <= r_geo[s-1];
            end
            for (int j = 0; j < cplc_pkg::MAX_VERTICES; j++) begin
                r_px[j]   <= n_px[j];
                r_py[j]   <= n_py[j];
                r_qx[j]   <= n_qx[j];
                r_qy[j]   <= n_qy[j];
                r_act[j]  <= w_act[j];
                r_num[j]  <= cplc_pkg::SUM_W'(r_px[j]) + cplc_pkg::SUM_W'(r_py[j]);
                r_dot[j]  <= cplc_pkg::SUM_W'(r_qx[j]) + cplc_pkg::SUM_W'(r_qy[j]);
                r_act2[j] <= r_act[j];
            end

            r_rej[cplc_pkg::ST_CAND] <= n_rej;
            for (int s = cplc_pkg::ST_CAND + 1; s < cplc_pkg::ST_FPROD; s++) begin
                r_rej[s] <= r_rej[s-1];
            end
            for (int k = 0; k < cplc_pkg::TREE_N; k++) begin
                r_lo[0][k] <= n_lo0[k];
                r_hi[0][k] <= n_hi0[k];
            end
            for (int l = 0; l < cplc_pkg::TREE_LVLS; l++) begin
                for (int k = 0; k < cplc_pkg::TREE_N; k++) begin
                    r_tl[l][k]   <= r_lo[l][k];
                    r_th[l][k]   <= r_hi[l][k];
                    r_lo[l+1][k] <= n_lo[l][k];
                    r_hi[l+1][k] <= n_hi[l][k];
                end
                for (int k = 0; k < cplc_pkg::TREE_N / 2; k++) begin
                    r_pla[l][k] <= n_pla[l][k];
                    r_plb[l][k] <= n_plb[l][k];
                    r_pha[l][k] <= n_pha[l][k];
                    r_phb[l][k] <= n_phb[l][k];
                end
            end

            r_fpa  <= cplc_pkg::CMP_W'(w_flo.num) * cplc_pkg::CMP_W'(w_fhi.den);
            r_fpb  <= cplc_pkg::CMP_W'(w_fhi.num) * cplc_pkg::CMP_W'(w_flo.den);
            r_frej <= r_rej[cplc_pkg::ST_FPROD-1];
            for (int c = 0; c < 4; c++) begin
                r_cb[c]   <= n_cb[c];
                r_cd[c]   <= n_cd[c];
                r_cden[c] <= n_cden[c];
            end

            r_dv_vis[0] <= n_dv_vis0;
            for (int c = 0; c < 4; c++) begin
                r_dv_rem[0][c] <= n_dv_rem[0][c];
                r_dv_q[0][c]   <= n_dv_q[0][c];
                r_dv_b[0][c]   <= n_dv_b0[c];
                r_dv_neg[0][c] <= n_dv_neg0[c];
            end
            for (int k = 1; k <= cplc_pkg::QUO_W; k++) begin
                r_dv_vis[k] <= r_dv_vis[k-1];
                for (int c = 0; c < 4; c++) begin
                    r_dv_rem[k][c] <= n_dv_rem[k][c];
                    r_dv_q[k][c]   <= n_dv_q[k][c];
                    r_dv_b[k][c]   <= r_dv_b[k-1][c];
                    r_dv_neg[k][c] <= r_dv_neg[k-1][c];
                end
            end

            r_out <= n_out;
        end
    end

endmodule

FILE: dv/cplc_clip_checker.sv
module cplc_clip_checker
    import cplc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_seg_valid,
    input  logic                    i_seg_stall,
    input  t_seg_in                 i_seg,
    input  logic                    i_clip_valid,
    input  logic                    i_clip_stall,
    input  t_clip_out               i_clip,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending
);

    longint    win_x [MAX_VERTICES];
    longint    win_y [MAX_VERTICES];
    logic [VCOUNT_W-1:0] win_count;
    t_clip_out clip_queue [$];

    function automatic longint sext_coord(logic [COORD_WIDTH-1:0] v);
        return longint'(signed'(v));
    endfunction

    // a/b against c/d, both denominators positive; products fit in 64 bits
    function automatic int frac_order(longint a, longint b, longint c, longint d);
        longint l;
        longint r;
        l = a * d;
        r = c * b;
        return (l > r) ? 1 : ((l < r) ? -1 : 0);
    endfunction

    function automatic logic [COORD_WIDTH-1:0] lerp_round(longint base, longint diff,
                                                         longint tn, longint td);
        longint num;
        longint q;
        num = base * td + diff * tn;
        if (num >= 0)
            q = (2 * num + td) / (2 * td);
        else
            q = -((2 * (-num) + td) / (2 * td));
        return q[COORD_WIDTH-1:0];
    endfunction

    function automatic t_clip_out clip_segment(t_seg_in s);
        longint x0, y0, dx, dy, nx, ny, num, dot;
        longint lo_n, lo_d, hi_n, hi_d;
        int     n, nj;
        bit     reject;
        t_clip_out r;
        x0 = sext_coord(s.x_start);
        y0 = sext_coord(s.y_start);
        dx = sext_coord(s.x_end) - x0;
        dy = sext_coord(s.y_end) - y0;
        lo_n = 0; lo_d = 1; hi_n = 1; hi_d = 1;
        reject = 1'b0;
        n = (win_count < VCOUNT_MIN) ? VCOUNT_MIN : int'(win_count);
        if (n > MAX_VERTICES) n = MAX_VERTICES;
        for (int j = 0; j < n; j++) begin
            nj  = (j + 1 == n) ? 0 : j + 1;
            nx  = -(win_y[nj] - win_y[j]);
            ny  = win_x[nj] - win_x[j];
            num = nx * (x0 - win_x[j]) + ny * (y0 - win_y[j]);
            dot = nx * dx + ny * dy;
            if (dot == 0) begin
                if (num < 0) reject = 1'b1;
            end else if (dot > 0) begin
                if (frac_order(-num, dot, lo_n, lo_d) > 0) begin
                    lo_n = -num;
                    lo_d = dot;
                end
            end else begin
                if (frac_order(num, -dot, hi_n, hi_d) < 0) begin
                    hi_n = num;
                    hi_d = -dot;
                end
            end
        end
        r = '0;
        if (!reject && frac_order(lo_n, lo_d, hi_n, hi_d) <= 0) begin
            r.visible      = 1'b1;
            r.clip_x_start = lerp_round(x0, dx, lo_n, lo_d);
            r.clip_y_start = lerp_round(y0, dy, lo_n, lo_d);
            r.clip_x_end   = lerp_round(x0, dx, hi_n, hi_d);
            r.clip_y_end   = lerp_round(y0, dy, hi_n, hi_d);
        end
        return r;
    endfunction

    task automatic report(string field, longint exp_v, longint act_v);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
        o_fail_count++;
    endtask

    assign o_pending = clip_queue.size();

    initial begin
        o_fail_count = 0;
    end

    always @(posedge i_clk) begin
        t_clip_out exp_c;
        int        k;
        if (!i_rst_n) begin
            win_count <= VCOUNT_W'(VCOUNT_RST);
            for (int v = 0; v < MAX_VERTICES; v++) begin
                win_x[v] <= 0;
                win_y[v] <= 0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_VCOUNT) begin
                    win_count <= i_cfg_data[VCOUNT_W-1:0];
                end else if (i_cfg_idx <= CFG_VERT_6_7) begin
                    for (int h = 0; h < 2; h++) begin
                        k = 2 * (int'(i_cfg_idx) - 1) + h;
                        if (k < MAX_VERTICES) begin
                            win_x[k] <= sext_coord(i_cfg_data[2*h*COORD_WIDTH +: COORD_WIDTH]);
                            win_y[k] <= sext_coord(i_cfg_data[(2*h+1)*COORD_WIDTH +: COORD_WIDTH]);
                        end
                    end
                end
            end
            if (i_seg_valid && !i_seg_stall)
                clip_queue.push_back(clip_segment(i_seg));
            if (i_clip_valid && !i_clip_stall) begin
                if (clip_queue.size() == 0) begin
                    $display("%0t: result with nothing expected, got %p", $time, i_clip);
                    o_fail_count++;
                end else begin
                    exp_c = clip_queue.pop_front();
                    if (i_clip.visible !== exp_c.visible)
                        report("visible", exp_c.visible, i_clip.visible);
                    if (i_clip.clip_x_start !== exp_c.clip_x_start)
                        report("clip_x_start", exp_c.clip_x_start, i_clip.clip_x_start);
                    if (i_clip.clip_y_start !== exp_c.clip_y_start)
                        report("clip_y_start", exp_c.clip_y_start, i_clip.clip_y_start);
                    if (i_clip.clip_x_end !== exp_c.clip_x_end)
                        report("clip_x_end", exp_c.clip_x_end, i_clip.clip_x_end);
                    if (i_clip.clip_y_end !== exp_c.clip_y_end)
                        report("clip_y_end", exp_c.clip_y_end, i_clip.clip_y_end);
                end
            end
        end
    end

endmodule

FILE: dv/tb_convex_polygon_line_clipper_unit.sv
module tb_convex_polygon_line_clipper_unit;
    import cplc_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int SEG_W      = 4 * COORD_WIDTH;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_seg_in               i_data = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_clip_out             o_data;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int fail_count;
    int clips_pending;
    bit hold_req = 1'b0;
    int idle_cycles = 0;
    int win_lo = -1000;
    int win_hi = 1000;

    convex_polygon_line_clipper_unit dut (.*);

    cplc_clip_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seg_valid  (i_valid),
        .i_seg_stall  (o_stall),
        .i_seg        (i_data),
        .i_clip_valid (o_valid),
        .i_clip_stall (i_stall),
        .i_clip       (o_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (clips_pending)
    );

    always #6 i_clk = ~i_clk;

    // Receiver: stall pattern switches among four random modes; one long hold-off on request
    initial begin
        int mode;
        int cyc;
        mode = 0;
        cyc  = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (200) @(posedge i_clk);
            end
            if (cyc % 64 == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 9) < 3);
                2: i_stall <= ($urandom_range(0, 9) < 7);
                default: i_stall <= ((cyc % 16) < 5);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_convex_polygon_line_clipper_unit: errors");
            $finish;
        end
    end

    function automatic logic [CFG_DATA_W-1:0] vert_pair(int xa, int ya, int xb, int yb);
        return {COORD_WIDTH'(yb), COORD_WIDTH'(xb), COORD_WIDTH'(ya), COORD_WIDTH'(xa)};
    endfunction

    function automatic t_seg_in seg(int xs, int ys, int xe, int ye);
        return '{x_start: COORD_WIDTH'(xs), y_start: COORD_WIDTH'(ys),
                 x_end: COORD_WIDTH'(xe), y_end: COORD_WIDTH'(ye)};
    endfunction

    function automatic int near_coord();
        return $urandom_range(win_hi - win_lo + 400) + win_lo - 200;
    endfunction

    function automatic t_seg_in random_seg();
        t_seg_in s;
        int      pick;
        pick = $urandom_range(0, 9);
        s = seg(near_coord(), near_coord(), near_coord(), near_coord());
        if (pick < 2) begin
            s = t_seg_in'(SEG_W'({$urandom, $urandom}));
        end else if (pick == 2) begin
            s.x_end = s.x_start;
            s.y_end = s.y_start;
        end else if (pick == 3) begin
            s.y_end = s.y_start;
        end else if (pick == 4) begin
            s.x_end = s.x_start;
        end
        return s;
    endfunction

    task automatic send_seg(t_seg_in s);
        i_valid <= 1'b1;
        i_data  <= s;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (clips_pending != 0) @(posedge i_clk);
        // covers the pipeline depth before any register write
        repeat (30) @(posedge i_clk);
    endtask

    // Drop the enable between writes so back-to-back writes never drive it twice at one edge
    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_traffic(int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && sent < count; b++) begin
                send_seg(random_seg());
                sent++;
            end
            if ($urandom_range(0, 4) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    endtask

    task automatic directed_square();
        send_seg(seg(-1500, 0, 1500, 0));
        send_seg(seg(-200, -300, 400, 500));
        send_seg(seg(1200, 1200, 1800, 1500));
        send_seg(seg(-1500, 1100, 1500, 1100));
        send_seg(seg(-1500, 1000, 1500, 1000));
        send_seg(seg(-1500, -1000, 1500, -1000));
        send_seg(seg(100, 100, 100, 100));
        send_seg(seg(1500, 100, 1500, 100));
        send_seg(seg(0, 2000, 2000, 0));
        send_seg(seg(500, 1500, 1500, 500));
        send_seg(seg(-2048, -2048, 2047, 2047));
        send_seg(seg(2047, -2048, -2048, 2047));
        send_seg(seg(2047, 2047, -2048, -2048));
        send_seg(seg(-2048, 0, 2047, 1));
        send_seg(seg(333, -1999, -777, 1999));
        send_seg(seg(1000, 1000, 1000, 1000));
        send_seg(seg(-2048, -2048, -2048, -2048));
        send_seg(seg(2047, 2047, 2047, 2047));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset window: every vertex at the origin, all edges zero length
        send_seg(seg(-5, -5, 5, 5));
        send_seg(seg(0, 0, 0, 0));
        send_seg(seg(-2048, 2047, 2047, -2048));
        drain();

        write_reg(CFG_VERT_0_1, vert_pair(-1000, -1000, 1000, -1000));
        write_reg(CFG_VERT_2_3, vert_pair(1000, 1000, -1000, 1000));
        write_reg(CFG_VCOUNT, CFG_DATA_W'(4));
        win_lo = -1000; win_hi = 1000;
        directed_square();
        random_traffic(120);
        // fill the pipeline against a long receiver hold-off
        hold_req = 1'b1;
        for (int k = 0; k < 60; k++) send_seg(random_seg());
        drain();

        write_reg(CFG_VERT_0_1, vert_pair(-1500, -1200, 1800, -900));
        write_reg(CFG_VERT_2_3, vert_pair(100, 1700, 0, 0));
        write_reg(CFG_VCOUNT, CFG_DATA_W'(3));
        win_lo = -1500; win_hi = 1800;
        random_traffic(140);
        drain();

        // octagon at the coordinate extremes
        write_reg(CFG_VERT_0_1, vert_pair(-1024, -2048, 1024, -2048));
        write_reg(CFG_VERT_2_3, vert_pair(2047, -1024, 2047, 1024));
        write_reg(CFG_VERT_4_5, vert_pair(1024, 2047, -1024, 2047));
        write_reg(CFG_VERT_6_7, vert_pair(-2048, 1024, -2048, -1024));
        write_reg(CFG_VCOUNT, CFG_DATA_W'(8));
        win_lo = -2048; win_hi = 2047;
        send_seg(seg(-2048, -2048, 2047, 2047));
        send_seg(seg(-2048, 2047, 2047, -2048));
        send_seg(seg(-2048, 0, 2047, 0));
        random_traffic(140);
        drain();

        // out-of-range counts clamp to the full octagon
        write_reg(CFG_VCOUNT, CFG_DATA_W'(15));
        random_traffic(100);
        drain();

        // count below minimum acts as a triangle on the first vertices
        write_reg(CFG_VERT_0_1, vert_pair(-3, -3, 4, -2));
        write_reg(CFG_VERT_2_3, vert_pair(1, 5, 2047, 2047));
        write_reg(CFG_VCOUNT, CFG_DATA_W'(0));
        win_lo = -10; win_hi = 10;
        random_traffic(100);
        drain();

        // clockwise square corners with count 2, which clamps to a triangle on the first three
        write_reg(CFG_VERT_0_1, vert_pair(-600, -600, -600, 600));
        write_reg(CFG_VERT_2_3, vert_pair(600, 600, 600, -600));
        write_reg(CFG_VCOUNT, CFG_DATA_W'(2));
        win_lo = -600; win_hi = 600;
        random_traffic(80);
        drain();

        // random, possibly non-convex, windows
        for (int p = 0; p < 4; p++) begin
            write_reg(CFG_VERT_0_1, CFG_DATA_W'({$urandom, $urandom}));
            write_reg(CFG_VERT_2_3, CFG_DATA_W'({$urandom, $urandom}));
            write_reg(CFG_VERT_4_5, CFG_DATA_W'({$urandom, $urandom}));
            write_reg(CFG_VERT_6_7, CFG_DATA_W'({$urandom, $urandom}));
            write_reg(CFG_VCOUNT, CFG_DATA_W'($urandom_range(3, 8)));
            win_lo = -2048; win_hi = 2047;
            random_traffic(40);
            drain();
        end

        if (fail_count == 0)
            $display("tb_convex_polygon_line_clipper_unit: clean");
        else
            $display("tb_convex_polygon_line_clipper_unit: errors");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/cplc_pkg.sv
rtl/core/convex_polygon_line_clipper_unit.sv
dv/cplc_clip_checker.sv
dv/tb_convex_polygon_line_clipper_unit.sv
